/* src/assert_macros.svh */
// Assertion macros shared by the oscillator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check an implication property on the rising clock edge, off during reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("oscillator assertion failed");

// Check that a condition never holds on a rising clock edge.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("oscillator forbidden condition");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* src/mwo_pkg.sv */
// Package of the oscillator: widths, beat types, register indexes and sine table.
package mwo_pkg;

	localparam int SINE_DEPTH = 256;
	localparam int FRAC_BITS  = 8;

	localparam int POS_W   = 24;
	localparam int AMP_W   = 15;
	localparam int DUTY_W  = 8;
	localparam int MODE_W  = 3;
	localparam int CFG_W   = 24;
	localparam int CIDX_W  = 3;
	localparam int MA_W    = 17;
	localparam int PROD_W  = MA_W + POS_W;
	localparam int NUM_W   = PROD_W + 1;
	localparam int DCNT_W  = $clog2(NUM_W);
	localparam int V_W     = NUM_W + 3;
	localparam int SMP_W   = 16;
	localparam int LOG_D   = $clog2(SINE_DEPTH);
	localparam int IDX_W   = LOG_D + 2;
	localparam int TIDX_W  = LOG_D + 1;
	localparam int PULSE_SHIFT = 8;
	localparam int Q15_SHIFT   = 15;

	localparam logic [POS_W-1:0]  POS_STEP   = POS_W'(1 << FRAC_BITS);
	localparam logic [MA_W-1:0]   SINE_SCALE = MA_W'(4 * SINE_DEPTH);
	localparam logic [PROD_W-1:0] Q15_HALF   = PROD_W'(1 << (Q15_SHIFT - 1));

	localparam longint unsigned Q30_ONE     = 64'd1073741824;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_WAVE_MODE = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_PERIOD    = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_AMPLITUDE = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_DUTY      = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_MUTED     = 3'd4;

	// waveform mode codes
	localparam logic [MODE_W-1:0] MODE_NONE   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SQUARE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SAW    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_PULSE  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SINE   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_TRI    = 3'd5;
	localparam logic [MODE_W-1:0] MODE_ITRI   = 3'd6;
	localparam logic [MODE_W-1:0] MODE_DSAW   = 3'd7;

	typedef struct packed {
		logic restart;
		logic buffer_end;
	} in_beat_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample_value;
		logic                    buffer_end_out;
	} out_beat_t;

	typedef logic [SMP_W-1:0] sine_tab_t [0:SINE_DEPTH];

	// Quarter-wave sine in Q15 from a degree-11 Taylor series in Q30.
	function automatic sine_tab_t build_sine();
		longint unsigned th;
		longint unsigned th2;
		longint unsigned t;
		longint unsigned s;
		longint unsigned q;
		sine_tab_t       tab;
		for (int k = 0; k <= SINE_DEPTH; k++) begin
			th  = (longint'(k) * HALF_PI_Q30 + SINE_DEPTH / 2) / SINE_DEPTH;
			th2 = (th * th) >> 30;
			t   = Q30_ONE;
			t   = Q30_ONE - ((th2 * t) >> 30) / 110;
			t   = Q30_ONE - ((th2 * t) >> 30) / 72;
			t   = Q30_ONE - ((th2 * t) >> 30) / 42;
			t   = Q30_ONE - ((th2 * t) >> 30) / 20;
			t   = Q30_ONE - ((th2 * t) >> 30) / 6;
			s   = (th * t) >> 30;
			q   = (s + 64'd16384) >> 15;
			if (q > 64'd32768) begin
				q = 64'd32768;
			end
			tab[k] = q[SMP_W-1:0];
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine();

endpackage

/* src/multi_waveform_oscillator.sv */
// Top level of the multi-waveform audio oscillator.
// One input beat asks for one audio sample; one output beat returns a signed
// 16-bit sample, saturated. Modes: silence, square, sawtooth, pulse, sine
// (quarter-wave table), triangle, inverted triangle and double saw. The
// phase position counts samples in unsigned Q16.8 and wraps by the configured
// period. Square and muted samples skip the multiplier and divider; pulse
// only multiplies and compares; ramps and sine use the bit-serial divider,
// which retires one quotient bit of a 42-bit numerator per cycle. One
// multiplier, used by pulse, ramp and sine, feeds the divider for ramps and
// sine. The block takes one beat at a time and holds in_stall high until the
// sample sits in the output register; that register lets the next beat in
// while the sample waits. Write configuration only while the block is idle.
module multi_waveform_oscillator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  mwo_pkg::in_beat_t          in_beat,
	output logic                       out_valid,
	input  logic                       out_stall,
	output mwo_pkg::out_beat_t         out_beat,
	input  logic                       cfg_we,
	input  logic [mwo_pkg::CIDX_W-1:0] cfg_index,
	input  logic [mwo_pkg::CFG_W-1:0]  cfg_data
);
	import mwo_pkg::*;

	`include "assert_macros.svh"

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_MUL,
		ST_PCMP,
		ST_DIVGO,
		ST_DIVWAIT,
		ST_TAB,
		ST_SMUL,
		ST_SRND,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_PULSE,
		OP_RAMP,
		OP_SINE
	} op_t;

	typedef enum logic [1:0] {
		RS_ZERO,
		RS_POS,
		RS_NEG
	} rsign_t;

	// configuration registers
	logic [MODE_W-1:0] mode_q;
	logic [POS_W-1:0]  period_q;
	logic [AMP_W-1:0]  amp_q;
	logic [DUTY_W-1:0] duty_q;
	logic              muted_q;

	// oscillator state
	logic [POS_W-1:0]  pos_q;
	logic [1:0]        seg_q;

	// sequencer and work registers
	state_t            state_q;
	op_t               op_q;
	rsign_t            rs_q;
	logic signed [3:0] ka_q;
	logic              restart_q;
	logic              bend_q;
	logic [MA_W-1:0]   ma_q;
	logic [POS_W-1:0]  mb_q;
	logic [PROD_W-1:0] prod_q;
	logic [NUM_W-1:0]  quot_q;
	logic [PROD_W-1:0] mul_p;

	logic              out_valid_q;
	out_beat_t         out_beat_q;

	// divider link
	logic              div_start;
	logic              div_done;
	logic [NUM_W-1:0]  div_num;
	logic [NUM_W-1:0]  div_quot;

	// segment decision terms
	logic [1:0]        seg_eff;
	logic              ge2;
	logic              ge4;
	logic              ge43;
	logic              gep;
	logic [POS_W-1:0]  pos_adv;
	logic [POS_W-1:0]  pos_sub;
	logic              is_m6;
	logic signed [3:0] off_mid;
	logic [MA_W-1:0]   amp_x2;
	logic [MA_W-1:0]   amp_x4;

	// sine lookup
	logic [IDX_W-1:0]  sidx;
	logic [LOG_D-1:0]  sj;
	logic [TIDX_W-1:0] tidx;

	// final sum
	logic signed [V_W-1:0]  r_term;
	logic signed [19:0]     ka_ext;
	logic signed [19:0]     amp_ext;
	logic signed [19:0]     ka_amp;
	logic signed [V_W-1:0]  v_sum;
	logic signed [SMP_W-1:0] v_sat;
	logic                   accept;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	// Segment borders are exact rational compares on the current position.
	assign seg_eff = restart_q ? 2'd0 : seg_q;
	assign ge2     = ({pos_q, 1'b0} >= {1'b0, period_q});
	assign ge4     = ({pos_q, 2'b00} >= {2'b00, period_q});
	assign ge43    = ({pos_q, 2'b00} >= ({2'b00, period_q} + {1'b0, period_q, 1'b0}));
	assign gep     = (pos_q >= period_q);
	assign pos_adv = pos_q + POS_STEP;
	assign pos_sub = pos_q - period_q;
	assign is_m6   = (mode_q == MODE_ITRI);
	assign off_mid = is_m6 ? -4'sd3 : -4'sd2;
	assign amp_x2  = {1'b0, amp_q, 1'b0};
	assign amp_x4  = {amp_q, 2'b00};

	// The one multiplier, used for ramps, sine index, duty point and sine level.
	assign mul_p = ma_q * mb_q;

	// Round half up: add half the period to the product.
	assign div_start = (state_q == ST_DIVGO);
	assign div_num   = {1'b0, prod_q} + NUM_W'(period_q >> 1);

	mwo_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (period_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Fold the table index onto the quarter wave; odd quadrants run backward.
	assign sidx = quot_q[IDX_W-1:0];
	assign sj   = sidx[LOG_D-1:0];
	assign tidx = sidx[LOG_D] ? (TIDX_W'(SINE_DEPTH) - {1'b0, sj}) : {1'b0, sj};

	// Sample = sign * ramp-or-sine term + small multiple of the amplitude.
	always_comb begin
		case (rs_q)
			RS_POS:  r_term = $signed({3'b000, quot_q});
			RS_NEG:  r_term = -$signed({3'b000, quot_q});
			default: r_term = '0;
		endcase
	end

	assign ka_ext  = 20'(ka_q);
	assign amp_ext = $signed({5'b00000, amp_q});
	assign ka_amp  = ka_ext * amp_ext;
	assign v_sum   = r_term + V_W'(ka_amp);

	always_comb begin
		if (v_sum > V_W'(32767)) begin
			v_sat = 16'sh7fff;
		end else if (v_sum < -V_W'(32768)) begin
			v_sat = -16'sh8000;
		end else begin
			v_sat = v_sum[SMP_W-1:0];
		end
	end

	// Take configuration writes; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NONE;
			period_q <= POS_W'(25600);
			amp_q    <= '0;
			duty_q   <= DUTY_W'(13);
			muted_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WAVE_MODE: mode_q   <= cfg_data[MODE_W-1:0];
				CFG_PERIOD:    period_q <= cfg_data[POS_W-1:0];
				CFG_AMPLITUDE: amp_q    <= cfg_data[AMP_W-1:0];
				CFG_DUTY:      duty_q   <= cfg_data[DUTY_W-1:0];
				CFG_MUTED:     muted_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer: decide segment and position, then run the shared multiplier
	// and divider as the mode needs, then saturate into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			seg_q       <= '0;
			op_q        <= OP_NONE;
			rs_q        <= RS_ZERO;
			ka_q        <= '0;
			restart_q   <= 1'b0;
			bend_q      <= 1'b0;
			ma_q        <= '0;
			mb_q        <= '0;
			prod_q      <= '0;
			quot_q      <= '0;
			out_valid_q <= 1'b0;
			out_beat_q  <= '0;
		end else begin
			// drop the output beat once taken; the final state reloads it itself
			if (out_valid_q && !out_stall && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						restart_q <= in_beat.restart;
						bend_q    <= in_beat.buffer_end;
						state_q   <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					seg_q   <= seg_eff;
					op_q    <= OP_NONE;
					rs_q    <= RS_ZERO;
					ka_q    <= '0;
					mb_q    <= pos_q;
					ma_q    <= amp_x4;
					state_q <= ST_MUL;
					if (muted_q || mode_q == MODE_NONE) begin
						pos_q   <= '0;
						state_q <= ST_FIN;
					end else begin
						case (mode_q)
							MODE_SQUARE: begin
								ka_q    <= ge2 ? 4'sd1 : -4'sd1;
								pos_q   <= gep ? pos_sub : pos_adv;
								state_q <= ST_FIN;
							end
							MODE_SAW: begin
								op_q <= OP_RAMP;
								rs_q <= RS_POS;
								ma_q <= amp_x2;
								if (seg_eff == 2'd0) begin
									if (ge2) begin
										seg_q <= 2'd1;
										ka_q  <= -4'sd1;
									end
									pos_q <= pos_adv;
								end else begin
									ka_q <= -4'sd2;
									if (gep) begin
										pos_q <= pos_sub;
										seg_q <= 2'd0;
									end else begin
										pos_q <= pos_adv;
									end
								end
							end
							MODE_PULSE: begin
								op_q  <= OP_PULSE;
								pos_q <= gep ? '0 : pos_adv;
								ma_q  <= MA_W'(duty_q);
								mb_q  <= period_q;
							end
							MODE_SINE: begin
								op_q  <= OP_SINE;
								rs_q  <= RS_POS;
								pos_q <= gep ? pos_sub : pos_adv;
								ma_q  <= SINE_SCALE;
								mb_q  <= gep ? pos_sub : pos_adv;
							end
							MODE_TRI: begin
								op_q <= OP_RAMP;
								case (seg_eff)
									2'd0: begin
										if (ge4) begin
											seg_q <= 2'd1;
											rs_q  <= RS_NEG;
											ka_q  <= 4'sd2;
										end else begin
											rs_q <= RS_POS;
										end
										pos_q <= pos_adv;
									end
									2'd1: begin
										if (ge43) begin
											seg_q <= 2'd2;
											rs_q  <= RS_POS;
											ka_q  <= -4'sd4;
										end else begin
											rs_q <= RS_NEG;
											ka_q <= 4'sd2;
										end
										pos_q <= pos_adv;
									end
									default: begin
										rs_q <= RS_POS;
										ka_q <= -4'sd4;
										if (gep) begin
											pos_q <= pos_sub;
											seg_q <= 2'd0;
										end else begin
											pos_q <= pos_adv;
										end
									end
								endcase
							end
							default: begin
								// inverted triangle and double saw
								op_q <= OP_RAMP;
								case (seg_eff)
									2'd0: begin
										if (ge4) begin
											seg_q <= 2'd1;
											rs_q  <= RS_POS;
											ka_q  <= -4'sd1;
										end else begin
											rs_q <= RS_NEG;
											ka_q <= 4'sd1;
										end
										pos_q <= pos_adv;
									end
									2'd1: begin
										rs_q <= RS_POS;
										if (ge2) begin
											seg_q <= 2'd2;
											ka_q  <= off_mid;
										end else begin
											ka_q <= is_m6 ? -4'sd1 : -4'sd2;
										end
										pos_q <= pos_adv;
									end
									2'd2: begin
										if (ge43) begin
											seg_q <= 2'd3;
											rs_q  <= RS_NEG;
											ka_q  <= 4'sd3;
										end else begin
											rs_q <= RS_POS;
											ka_q <= off_mid;
										end
										pos_q <= pos_adv;
									end
									default: begin
										rs_q <= RS_NEG;
										ka_q <= 4'sd3;
										if (gep) begin
											pos_q <= pos_sub;
											seg_q <= 2'd0;
										end else begin
											pos_q <= pos_adv;
										end
									end
								endcase
							end
						endcase
					end
				end
				ST_MUL: begin
					prod_q  <= mul_p;
					state_q <= (op_q == OP_PULSE) ? ST_PCMP : ST_DIVGO;
				end
				ST_PCMP: begin
					// high part once the new position passes the duty point
					ka_q    <= ({9'b0, pos_q, PULSE_SHIFT'(0)} >= prod_q) ? 4'sd1 : -4'sd1;
					state_q <= ST_FIN;
				end
				ST_DIVGO: begin
					state_q <= ST_DIVWAIT;
				end
				ST_DIVWAIT: begin
					if (div_done) begin
						if (period_q == '0) begin
							quot_q  <= '0;
							rs_q    <= RS_ZERO;
							state_q <= ST_FIN;
						end else begin
							quot_q  <= div_quot;
							state_q <= (op_q == OP_SINE) ? ST_TAB : ST_FIN;
						end
					end
				end
				ST_TAB: begin
					ma_q    <= MA_W'(amp_q);
					mb_q    <= POS_W'(SINE_TAB[tidx]);
					rs_q    <= sidx[IDX_W-1] ? RS_NEG : RS_POS;
					state_q <= ST_SMUL;
				end
				ST_SMUL: begin
					prod_q  <= mul_p;
					state_q <= ST_SRND;
				end
				ST_SRND: begin
					quot_q  <= NUM_W'((prod_q + Q15_HALF) >> Q15_SHIFT);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					// hold until the output register is free or drains this cycle
					if (!out_valid_q || !out_stall) begin
						out_valid_q                <= 1'b1;
						out_beat_q.sample_value    <= v_sat;
						out_beat_q.buffer_end_out  <= bend_q;
						state_q                    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_beat_q;

	`ASSERT_CLK(a_out_from_fin, clk, arst_n, $rose(out_valid) |-> $past(state_q == ST_FIN))
	`ASSERT_CLK(a_accept_decide, clk, arst_n, accept |=> state_q == ST_DECIDE)
	`ASSERT_NEVER(a_div_done_stray, clk, arst_n, div_done && state_q != ST_DIVWAIT)

endmodule

/* src/mwo_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module mwo_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [mwo_pkg::NUM_W-1:0] num,
	input  logic [mwo_pkg::POS_W-1:0] den,
	output logic                      done,
	output logic [mwo_pkg::NUM_W-1:0] quot
);
	import mwo_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [NUM_W-1:0]  acc_q;
	logic [POS_W:0]    rem_q;
	logic [POS_W:0]    rem_sh;
	logic              fits;

	assign rem_sh = {rem_q[POS_W-1:0], acc_q[NUM_W-1]};
	assign fits   = (rem_sh >= {1'b0, den});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, den}) : rem_sh;
			acc_q <= {acc_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = acc_q;

endmodule
